// ----- design/fdcwr_pkg.sv -----
// ----------------------------------------------------------------------------
// fdcwr_pkg: shared types, constants and functions of the floppy word reader
// Holds the command codes, the port codes, the bit positions of the control
// and status words, the result and status structures and the CRC-16 helpers.
// ----------------------------------------------------------------------------
package fdcwr_pkg;

    // Fixed field widths.
    localparam int CmdW  = 2;
    localparam int WordW = 16;
    localparam int ByteW = 8;
    localparam int DrvW  = 2;

    // Default number of attached drives.
    localparam int DriveCountDefault = 4;

    // Command codes.
    localparam logic [CmdW-1:0] CmdBusRead  = 2'd0;
    localparam logic [CmdW-1:0] CmdBusWrite = 2'd1;
    localparam logic [CmdW-1:0] CmdDiskByte = 2'd2;
    localparam logic [CmdW-1:0] CmdNop      = 2'd3;

    // Port codes.
    localparam logic PortStatus = 1'b0;
    localparam logic PortData   = 1'b1;

    // Control word bit positions.
    localparam int CtlSelLo   = 0;
    localparam int CtlMotor   = 4;
    localparam int CtlSide    = 5;
    localparam int CtlStepFwd = 6;
    localparam int CtlStep    = 7;
    localparam int CtlBlock   = 8;

    // Status word bit positions.
    localparam int StsTrack0  = 0;
    localparam int StsReady   = 1;
    localparam int StsWrProt  = 2;
    localparam int StsDataReq = 7;
    localparam int StsCrcZero = 14;
    localparam int StsIndex   = 15;

    // CRC-16 CCITT.
    localparam logic [WordW-1:0] CrcPoly = 16'h1021;
    localparam logic [WordW-1:0] CrcInit = 16'hFFFF;

    // One result item.
    typedef struct packed {
        logic [WordW-1:0] read_data;
        logic [DrvW-1:0]  selected_drive;
        logic             motor_on;
        logic             head_side;
        logic             step_pulse;
        logic             step_forward;
        logic             data_request;
    } result_t;

    // Internal state visible to the top level for checking.
    typedef struct packed {
        logic phase_reading;
        logic marker_blocked;
    } core_status_t;

    // Advance the CRC by one byte, MSB first.
    function automatic logic [WordW-1:0] crc16_byte(input logic [WordW-1:0] crc_in,
                                                    input logic [ByteW-1:0] data);
        logic [WordW-1:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < ByteW; i++) begin
            if (crc[WordW-1]) begin
                crc = {crc[WordW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                crc = {crc[WordW-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // Advance the CRC by one word, high byte first.
    function automatic logic [WordW-1:0] crc16_word(input logic [WordW-1:0] crc_in,
                                                    input logic [WordW-1:0] data);
        return crc16_byte(crc16_byte(crc_in, data[WordW-1:ByteW]), data[ByteW-1:0]);
    endfunction

endpackage

// ----- design/fdcwr_core.sv -----
// ----------------------------------------------------------------------------
// fdcwr_core: controller state and combinational transaction decode
// Holds the drive, motor, side, phase, byte pairing and CRC registers. The
// result of the presented transaction is formed combinationally; the state
// advances on the clock edge at which the transaction is taken.
// ----------------------------------------------------------------------------
module fdcwr_core #(
    parameter int DRIVE_COUNT = fdcwr_pkg::DriveCountDefault
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            take,
    input  logic [fdcwr_pkg::CmdW-1:0]      command,
    input  logic                            port,
    input  logic [fdcwr_pkg::WordW-1:0]     write_value,
    input  logic [fdcwr_pkg::ByteW-1:0]     disk_byte,
    input  logic                            byte_is_marker,
    input  logic                            track_zero,
    input  logic                            disk_present,
    input  logic                            write_protect,
    input  logic                            index_pulse,
    output fdcwr_pkg::result_t              result,
    output fdcwr_pkg::core_status_t         status
);

    logic                          phase_reg,   phase_next;
    logic                          blocked_reg, blocked_next;
    logic [fdcwr_pkg::WordW-1:0]   shift_reg,   shift_next;
    logic                          parity_reg,  parity_next;
    logic [fdcwr_pkg::WordW-1:0]   word_reg,    word_next;
    logic                          request_reg, request_next;
    logic [fdcwr_pkg::WordW-1:0]   crc_reg,     crc_next;
    logic [fdcwr_pkg::DrvW-1:0]    drive_reg,   drive_next;
    logic [DRIVE_COUNT-1:0]        motor_reg,   motor_next;
    logic                          side_reg,    side_next;

    logic                          motor_cur;
    logic                          motor_new;
    logic                          ready;
    logic                          start;
    logic                          phase_eff;
    logic                          parity_eff;
    logic [fdcwr_pkg::WordW-1:0]   shift_base;
    logic [fdcwr_pkg::WordW-1:0]   shift_new;
    logic [fdcwr_pkg::WordW-1:0]   crc_base;
    logic [fdcwr_pkg::DrvW-1:0]    sel_drive;
    logic                          sel_valid;
    logic [fdcwr_pkg::WordW-1:0]   rd;
    logic                          step;
    logic                          fwd;

    // Motor state of the currently selected drive.
    always_comb begin
        motor_cur = 1'b0;
        for (int i = 0; i < DRIVE_COUNT; i++) begin
            if (drive_reg == fdcwr_pkg::DrvW'(i)) begin
                motor_cur = motor_reg[i];
            end
        end
    end

    // Lowest set select bit names the drive; absent drives are ignored.
    always_comb begin
        sel_drive = '0;
        sel_valid = 1'b0;
        for (int i = fdcwr_pkg::CtlSelLo + 3; i >= fdcwr_pkg::CtlSelLo; i--) begin
            if (write_value[i]) begin
                sel_drive = fdcwr_pkg::DrvW'(i - fdcwr_pkg::CtlSelLo);
                sel_valid = (i - fdcwr_pkg::CtlSelLo) < DRIVE_COUNT;
            end
        end
    end

    // Disk byte path: marker start, byte pairing and CRC base.
    assign ready      = disk_present && motor_cur;
    assign start      = !phase_reg && !blocked_reg && byte_is_marker;
    assign phase_eff  = phase_reg || start;
    assign parity_eff = start ? 1'b0 : parity_reg;
    assign shift_base = start ? '0 : shift_reg;
    assign shift_new  = {shift_base[fdcwr_pkg::ByteW-1:0], disk_byte};
    assign crc_base   = start ? fdcwr_pkg::CrcInit : crc_reg;

    // Next state and the read value of this transaction.
    always_comb begin
        phase_next   = phase_reg;
        blocked_next = blocked_reg;
        shift_next   = shift_reg;
        parity_next  = parity_reg;
        word_next    = word_reg;
        request_next = request_reg;
        crc_next     = crc_reg;
        drive_next   = drive_reg;
        motor_next   = motor_reg;
        side_next    = side_reg;
        motor_new    = motor_cur;
        rd           = '0;
        step         = 1'b0;
        fwd          = 1'b0;

        unique case (command)
            fdcwr_pkg::CmdBusRead: begin
                if (port == fdcwr_pkg::PortData) begin
                    rd           = request_reg ? word_reg : '0;
                    request_next = 1'b0;
                end else begin
                    rd[fdcwr_pkg::StsTrack0]  = track_zero;
                    rd[fdcwr_pkg::StsReady]   = ready;
                    rd[fdcwr_pkg::StsWrProt]  = write_protect;
                    rd[fdcwr_pkg::StsDataReq] = request_reg;
                    rd[fdcwr_pkg::StsCrcZero] = (crc_reg == '0);
                    rd[fdcwr_pkg::StsIndex]   = index_pulse && ready;
                end
            end
            fdcwr_pkg::CmdBusWrite: begin
                if (port == fdcwr_pkg::PortStatus) begin
                    if (sel_valid) begin
                        drive_next = sel_drive;
                    end
                    for (int i = 0; i < DRIVE_COUNT; i++) begin
                        if (drive_next == fdcwr_pkg::DrvW'(i)) begin
                            motor_next[i] = write_value[fdcwr_pkg::CtlMotor];
                        end
                    end
                    motor_new = write_value[fdcwr_pkg::CtlMotor];
                    side_next = write_value[fdcwr_pkg::CtlSide];
                    step      = write_value[fdcwr_pkg::CtlStep];
                    fwd       = write_value[fdcwr_pkg::CtlStep]
                                && write_value[fdcwr_pkg::CtlStepFwd];
                    blocked_next = write_value[fdcwr_pkg::CtlBlock];
                    if (write_value[fdcwr_pkg::CtlBlock]) begin
                        phase_next   = 1'b0;
                        request_next = 1'b0;
                    end
                end
            end
            fdcwr_pkg::CmdDiskByte: begin
                if (motor_cur) begin
                    if (start) begin
                        request_next = 1'b0;
                        crc_next     = fdcwr_pkg::CrcInit;
                    end
                    if (phase_eff) begin
                        phase_next  = 1'b1;
                        shift_next  = shift_new;
                        parity_next = !parity_eff;
                        if (parity_eff) begin
                            word_next    = shift_new;
                            crc_next     = fdcwr_pkg::crc16_word(crc_base, shift_new);
                            request_next = 1'b1;
                        end
                    end
                end
            end
            fdcwr_pkg::CmdNop: begin
            end
            default: begin
            end
        endcase
    end

    // Result of the presented transaction.
    always_comb begin
        result.read_data      = rd;
        result.selected_drive = drive_next;
        result.motor_on       = motor_new;
        result.head_side      = side_next;
        result.step_pulse     = step;
        result.step_forward   = fwd;
        result.data_request   = request_next;
    end

    assign status.phase_reading  = phase_reg;
    assign status.marker_blocked = blocked_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 1'b0;
            blocked_reg <= 1'b0;
            shift_reg   <= '0;
            parity_reg  <= 1'b0;
            word_reg    <= '0;
            request_reg <= 1'b0;
            crc_reg     <= fdcwr_pkg::CrcInit;
            drive_reg   <= '0;
            motor_reg   <= '0;
            side_reg    <= 1'b0;
        end else if (take) begin
            phase_reg   <= phase_next;
            blocked_reg <= blocked_next;
            shift_reg   <= shift_next;
            parity_reg  <= parity_next;
            word_reg    <= word_next;
            request_reg <= request_next;
            crc_reg     <= crc_next;
            drive_reg   <= drive_next;
            motor_reg   <= motor_next;
            side_reg    <= side_next;
        end
    end

endmodule

// ----- design/floppy_controller_word_reader.sv -----
// ----------------------------------------------------------------------------
// floppy_controller_word_reader: floppy controller read path, word oriented
// Serves bus reads and writes of the status/control and data ports and pairs
// disk bytes into words with a running CRC-16.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_*       in         tuser: command; tdata: port, control word, disk byte,
//                       marker and drive condition flags
//  m_*       out        tdata: read value, drive, motor, side, step, request
//
//  Every transaction is decoded in the cycle it is taken and its result is
//  registered, so one transaction is accepted per cycle while s_tready is high.
//  A two-entry output register (main plus skid) keeps s_tready high while one
//  result waits on a stalled m_tready; s_tready drops only when both are full.
//  A result reaches m_tvalid from the main slot, via the skid slot if main is stalled.
//  aresetn is synchronous and clears all control state and the valid flags of both output slots.
// ----------------------------------------------------------------------------
module floppy_controller_word_reader #(
    parameter int DRIVE_COUNT = fdcwr_pkg::DriveCountDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] port, [16:1] write_value, [24:17] disk_byte, [25] byte_is_marker,
    // [26] track_zero, [27] disk_present, [28] write_protect, [29] index_pulse
    input  logic [31:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] read_data, [17:16] selected_drive, [18] motor_on, [19] head_side,
    // [20] step_pulse, [21] step_forward, [22] data_request
    output logic [23:0] m_tdata
);

    logic                     take;
    fdcwr_pkg::result_t       result;
    fdcwr_pkg::core_status_t  status;

    logic                     main_valid_reg, main_valid_next;
    fdcwr_pkg::result_t       main_reg,       main_next;
    logic                     skid_valid_reg, skid_valid_next;
    fdcwr_pkg::result_t       skid_reg,       skid_next;

    assign s_tready = !skid_valid_reg;
    assign take     = s_tvalid && s_tready;

    fdcwr_core #(
        .DRIVE_COUNT(DRIVE_COUNT)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .command       (s_tuser),
        .port          (s_tdata[0]),
        .write_value   (s_tdata[16:1]),
        .disk_byte     (s_tdata[24:17]),
        .byte_is_marker(s_tdata[25]),
        .track_zero    (s_tdata[26]),
        .disk_present  (s_tdata[27]),
        .write_protect (s_tdata[28]),
        .index_pulse   (s_tdata[29]),
        .result        (result),
        .status        (status)
    );

    // Output slots: the skid slot holds a result taken while the main slot
    // is stalled, and refills the main slot first.
    always_comb begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = take;
                main_next       = result;
            end
        end else if (take) begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {1'b0,
                       main_reg.data_request,
                       main_reg.step_forward,
                       main_reg.step_pulse,
                       main_reg.head_side,
                       main_reg.motor_on,
                       main_reg.selected_drive,
                       main_reg.read_data};

`ifndef SYNTHESIS
    // The skid slot is only ever filled behind a full main slot.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot holds a result while the main slot is empty");

    // A marker block always leaves the block in seek phase.
    a_blocked_in_seek: assert property (@(posedge aclk) disable iff (!aresetn)
        status.marker_blocked |-> !status.phase_reading)
        else $error("read phase active while markers are blocked");

    // A step direction is only reported together with a step pulse.
    a_fwd_with_step: assert property (@(posedge aclk) disable iff (!aresetn)
        main_valid_reg && main_reg.step_forward |-> main_reg.step_pulse)
        else $error("step direction reported without a step pulse");

    // A result taken into a stalled main slot is presented on the next free cycle.
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_tready |=> main_valid_reg && !skid_valid_reg)
        else $error("skid slot did not drain into the main slot");
`endif

endmodule
